### design/tcpw_pkg.sv
// Shared types and constants for the text character pixel writer.
// No dependencies; used by the interfaces, the top level and the testbench.
package tcpw_pkg;

    localparam int SCREEN_WIDTH_DEF  = 720;
    localparam int SCREEN_HEIGHT_DEF = 351;
    localparam int LINE_STRIDE_DEF   = 720;
    localparam int FONT_GLYPHS_DEF   = 256;

    localparam int GLYPH_COLS      = 6;
    localparam int GLYPH_ROWS      = 8;
    localparam int BYTES_PER_GLYPH = 5;

    localparam int KIND_W   = 2;
    localparam int FADDR_W  = 11;
    localparam int BYTE_W   = 8;
    localparam int COORD_W  = 12;
    localparam int PADDR_W  = 18;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic signed [COORD_W:0] ROW_MAX = 13'sd2047;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD   = 2'd0,
        KIND_CURSOR = 2'd1,
        KIND_CHAR   = 2'd2
    } t_kind;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_TEXT_COLOR = 1'b0,
        REG_BG_COLOR   = 1'b1
    } t_reg;

endpackage

### design/tcpw_in_if.sv
// Command channel of the text character pixel writer.
// Depends on tcpw_pkg for field widths.
interface tcpw_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [tcpw_pkg::KIND_W-1:0]          kind;
    logic [tcpw_pkg::FADDR_W-1:0]         font_address;
    logic [tcpw_pkg::BYTE_W-1:0]          font_byte;
    logic signed [tcpw_pkg::COORD_W-1:0]  start_x;
    logic signed [tcpw_pkg::COORD_W-1:0]  start_y;
    logic [tcpw_pkg::BYTE_W-1:0]          char_code;

    modport source (output valid, kind, font_address, font_byte, start_x, start_y,
                    char_code, input ready);
    modport sink   (input valid, kind, font_address, font_byte, start_x, start_y,
                    char_code, output ready);
endinterface

### design/tcpw_out_if.sv
// Pixel write channel of the text character pixel writer.
// Depends on tcpw_pkg for field widths.
interface tcpw_out_if;
    logic                          valid;
    logic                          ready;
    logic [tcpw_pkg::PADDR_W-1:0]  pixel_address;
    logic [tcpw_pkg::BYTE_W-1:0]   pixel_color;
    logic                          last;

    modport source (output valid, pixel_address, pixel_color, last, input ready);
    modport sink   (input valid, pixel_address, pixel_color, last, output ready);
endinterface

### design/tcpw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcpw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1280
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/text_char_pixel_writer.sv
// Text character pixel writer: turns commands into frame-buffer pixel words.
// Font load, cursor set, unused and off-screen commands complete in the accept cycle. An
// on-screen character goes from accept through setup (stride multiply, first font read), load
// (x offset), a scan of the 48 glyph cells (one cell per cycle through one shared address
// adder, unless the output stalls) and flush; the next command is taken after flush.
// Synchronous active-low reset clears cursor, colors and control only.
module text_char_pixel_writer #(
    parameter int SCREEN_WIDTH  = tcpw_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = tcpw_pkg::SCREEN_HEIGHT_DEF,
    parameter int LINE_STRIDE   = tcpw_pkg::LINE_STRIDE_DEF,
    parameter int FONT_GLYPHS   = tcpw_pkg::FONT_GLYPHS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    tcpw_in_if.sink                     i_in,
    tcpw_out_if.source                  o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tcpw_pkg::APB_AW-1:0] paddr,
    input  logic [tcpw_pkg::APB_DW-1:0] pwdata,
    output logic [tcpw_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);

    localparam int FONT_DEPTH = FONT_GLYPHS * tcpw_pkg::BYTES_PER_GLYPH;
    localparam int FA_W       = $clog2(FONT_DEPTH);
    localparam int CW         = tcpw_pkg::COORD_W;
    localparam int AW         = tcpw_pkg::PADDR_W;
    localparam int BW         = tcpw_pkg::BYTE_W;

    localparam logic [CW-1:0]          W12       = CW'(SCREEN_WIDTH);
    localparam logic [CW-1:0]          H12       = CW'(SCREEN_HEIGHT);
    localparam logic [AW-1:0]          STRIDE_A  = AW'(LINE_STRIDE);
    localparam logic signed [CW:0]     COL_LIMIT = (CW+1)'(SCREEN_WIDTH - tcpw_pkg::GLYPH_COLS);
    localparam logic [8:0]             GLYPHS9   = 9'(FONT_GLYPHS);
    localparam logic [2:0]             COL_END   = 3'(tcpw_pkg::GLYPH_COLS - 1);
    localparam logic [2:0]             ROW_END   = 3'(tcpw_pkg::GLYPH_ROWS - 1);
    localparam logic [2:0]             FONT_COLS = 3'(tcpw_pkg::BYTES_PER_GLYPH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_LOAD,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    t_state               r_state;
    logic [BW-1:0]        r_text_color;
    logic [BW-1:0]        r_bg_color;
    logic signed [CW-1:0] r_cur_col;
    logic signed [CW-1:0] r_cur_row;
    logic [BW-1:0]        r_code;
    logic [2:0]           r_col;
    logic [2:0]           r_row;
    logic [BW-1:0]        r_bits;
    logic [CW-1:0]        r_px;
    logic [CW-1:0]        r_py;
    logic [AW-1:0]        r_addr;
    logic [AW-1:0]        r_col_addr;
    logic                 r_pend_valid;
    logic [AW-1:0]        r_pend_addr;
    logic [BW-1:0]        r_pend_color;
    logic                 r_out_valid;
    logic [AW-1:0]        r_out_addr;
    logic [BW-1:0]        r_out_color;
    logic                 r_out_last;

    // ---------------- configuration port ----------------
    logic w_cfg_we;
    assign w_cfg_we = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    always_comb begin
        unique case (tcpw_pkg::t_reg'(paddr[2]))
            tcpw_pkg::REG_TEXT_COLOR: prdata = {{(tcpw_pkg::APB_DW-BW){1'b0}}, r_text_color};
            tcpw_pkg::REG_BG_COLOR:   prdata = {{(tcpw_pkg::APB_DW-BW){1'b0}}, r_bg_color};
            default:                  prdata = '0;
        endcase
    end

    // ---------------- input decode ----------------
    logic w_in_acc;
    logic w_on_screen;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_on_screen = !r_cur_col[CW-1] && ($unsigned(r_cur_col) < W12)
                      && !r_cur_row[CW-1] && ($unsigned(r_cur_row) < H12);

    // ---------------- cursor advance ----------------
    logic signed [CW:0]   w_col_sum;
    logic signed [CW:0]   w_row_sum;
    logic signed [CW-1:0] n_adv_col;
    logic signed [CW-1:0] n_adv_row;
    always_comb begin
        w_col_sum = {r_cur_col[CW-1], r_cur_col} + (CW+1)'(tcpw_pkg::GLYPH_COLS);
        w_row_sum = {r_cur_row[CW-1], r_cur_row} + (CW+1)'(tcpw_pkg::GLYPH_ROWS);
        if (w_col_sum > COL_LIMIT) begin
            n_adv_col = '0;
            n_adv_row = (w_row_sum > tcpw_pkg::ROW_MAX) ? tcpw_pkg::ROW_MAX[CW-1:0]
                                                       : w_row_sum[CW-1:0];
        end else begin
            n_adv_col = w_col_sum[CW-1:0];
            n_adv_row = r_cur_row;
        end
    end

    // ---------------- font RAM ----------------
    logic                 w_glyph_ok;
    logic [10:0]          w_glyph_base;
    logic [2:0]           w_rd_col;
    logic                 w_rd_ok;
    logic [10:0]          w_rd_full;
    logic [FA_W-1:0]      w_raddr;
    logic                 w_font_we;
    logic [BW-1:0]        w_rdata;
    logic [BW-1:0]        w_next_bits;

    assign w_glyph_ok   = {1'b0, r_code} < GLYPHS9;
    assign w_glyph_base = {1'b0, r_code, 2'b00} + {3'b000, r_code};
    // read column 0 in setup, then always prefetch the column after the one scanned
    assign w_rd_col     = (r_state == ST_SETUP) ? 3'd0 : r_col + 3'd1;
    assign w_rd_ok      = w_glyph_ok && (w_rd_col < FONT_COLS);
    assign w_rd_full    = w_glyph_base + {8'd0, w_rd_col};
    assign w_raddr      = w_rd_ok ? w_rd_full[FA_W-1:0] : '0;
    assign w_next_bits  = w_rd_ok ? w_rdata : '0;
    assign w_font_we    = w_in_acc && (i_in.kind == tcpw_pkg::KIND_LOAD)
                       && (i_in.font_address < 11'(FONT_DEPTH));

    tcpw_ram #(
        .WIDTH (BW),
        .DEPTH (FONT_DEPTH)
    ) u_font_ram (
        .i_clk   (i_clk),
        .i_we    (w_font_we),
        .i_waddr (i_in.font_address[FA_W-1:0]),
        .i_wdata (i_in.font_byte),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // ---------------- scan datapath ----------------
    logic [AW-1:0] w_prod;
    logic          w_row_end;
    logic          w_pos_last;
    logic [AW-1:0] w_add_a;
    logic [AW-1:0] w_add_b;
    logic [AW-1:0] w_sum;
    logic          w_emit;
    logic [BW-1:0] w_color;
    logic          w_can_push;
    logic          w_need_push;
    logic          w_advance;
    logic          w_out_load;

    // frame-buffer address wraps at its width, so the low bits of the product suffice
    assign w_prod     = STRIDE_A * AW'(r_cur_row[CW-2:0]);
    assign w_row_end  = (r_row == ROW_END);
    assign w_pos_last = w_row_end && (r_col == COL_END);

    // the one shared adder: x offset in load, then row stride or next column start
    always_comb begin
        if (r_state == ST_LOAD) begin
            w_add_a = r_addr;
            w_add_b = AW'($unsigned(r_cur_col));
        end else if (w_row_end) begin
            w_add_a = r_col_addr;
            w_add_b = AW'(1);
        end else begin
            w_add_a = r_addr;
            w_add_b = STRIDE_A;
        end
    end
    assign w_sum = w_add_a + w_add_b;

    assign w_color     = r_bits[0] ? r_text_color : r_bg_color;
    assign w_emit      = (r_bits[0] || (r_text_color != r_bg_color))
                      && (r_px < W12) && (r_py < H12);
    assign w_can_push  = !r_out_valid || o_out.ready;
    // a new pixel pushes the held one out; the held one goes last at flush
    assign w_need_push = w_emit && r_pend_valid;
    assign w_advance   = !w_need_push || w_can_push;
    assign w_out_load  = w_can_push && (((r_state == ST_SCAN) && w_need_push)
                                     || ((r_state == ST_FLUSH) && r_pend_valid));

    // ---------------- state and registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_text_color <= '0;
            r_bg_color   <= '0;
            r_cur_col    <= '0;
            r_cur_row    <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_cfg_we) begin
                unique case (tcpw_pkg::t_reg'(paddr[2]))
                    tcpw_pkg::REG_TEXT_COLOR: r_text_color <= pwdata[BW-1:0];
                    tcpw_pkg::REG_BG_COLOR:   r_bg_color   <= pwdata[BW-1:0];
                    default: ;
                endcase
            end

            if (r_out_valid && o_out.ready && !w_out_load) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_code <= i_in.char_code;
                        unique case (i_in.kind)
                            tcpw_pkg::KIND_CURSOR: begin
                                r_cur_col <= i_in.start_x;
                                r_cur_row <= i_in.start_y;
                            end
                            tcpw_pkg::KIND_CHAR: begin
                                if (w_on_screen) begin
                                    r_state <= ST_SETUP;
                                end else begin
                                    r_cur_col <= n_adv_col;
                                    r_cur_row <= n_adv_row;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SETUP: begin
                    r_addr  <= w_prod;
                    r_state <= ST_LOAD;
                end
                ST_LOAD: begin
                    r_addr     <= w_sum;
                    r_col_addr <= w_sum;
                    r_px       <= $unsigned(r_cur_col);
                    r_py       <= $unsigned(r_cur_row);
                    r_col      <= '0;
                    r_row      <= '0;
                    r_bits     <= w_glyph_ok ? w_rdata : '0;
                    r_state    <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (w_advance) begin
                        if (w_need_push) begin
                            r_out_valid <= 1'b1;
                            r_out_addr  <= r_pend_addr;
                            r_out_color <= r_pend_color;
                            r_out_last  <= 1'b0;
                        end
                        if (w_emit) begin
                            r_pend_valid <= 1'b1;
                            r_pend_addr  <= r_addr;
                            r_pend_color <= w_color;
                        end
                        if (w_pos_last) begin
                            r_state <= ST_FLUSH;
                        end else if (w_row_end) begin
                            r_addr     <= w_sum;
                            r_col_addr <= w_sum;
                            r_px       <= r_px + CW'(1);
                            r_py       <= $unsigned(r_cur_row);
                            r_row      <= '0;
                            r_col      <= r_col + 3'd1;
                            r_bits     <= w_next_bits;
                        end else begin
                            r_addr <= w_sum;
                            r_py   <= r_py + CW'(1);
                            r_row  <= r_row + 3'd1;
                            r_bits <= {1'b0, r_bits[BW-1:1]};
                        end
                    end
                end
                ST_FLUSH: begin
                    if (!r_pend_valid || w_can_push) begin
                        if (r_pend_valid) begin
                            r_out_valid <= 1'b1;
                            r_out_addr  <= r_pend_addr;
                            r_out_color <= r_pend_color;
                            r_out_last  <= 1'b1;
                        end
                        r_pend_valid <= 1'b0;
                        r_cur_col    <= n_adv_col;
                        r_cur_row    <= n_adv_row;
                        r_state      <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.pixel_address = r_out_addr;
    assign o_out.pixel_color   = r_out_color;
    assign o_out.last          = r_out_last;

    // ---------------- assertions ----------------
    a_pend_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_state == ST_SCAN || r_state == ST_FLUSH))
        else $error("held pixel outside of a character scan");

    a_px_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_px == $unsigned(r_cur_col) + {9'd0, r_col}))
        else $error("pixel column out of step with glyph column");

    a_py_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_py == $unsigned(r_cur_row) + {9'd0, r_row}))
        else $error("pixel row out of step with glyph row");

    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SETUP) |=> (r_state == ST_LOAD) && !i_in.ready)
        else $error("character setup did not move to font load");

endmodule

### sim/text_char_pixel_writer_tb.sv
// Self-checking testbench for text_char_pixel_writer: commands in, pixel words out.
// Depends on tcpw_pkg and the tcpw_in_if / tcpw_out_if interfaces of the design.
`timescale 1ns / 1ps

module text_char_pixel_writer_tb;

    localparam int KW           = tcpw_pkg::KIND_W;
    localparam int FW           = tcpw_pkg::FADDR_W;
    localparam int BW           = tcpw_pkg::BYTE_W;
    localparam int CW           = tcpw_pkg::COORD_W;
    localparam int AW           = tcpw_pkg::PADDR_W;
    localparam int GCOLS        = tcpw_pkg::GLYPH_COLS;
    localparam int GROWS        = tcpw_pkg::GLYPH_ROWS;
    localparam int GBYTES       = tcpw_pkg::BYTES_PER_GLYPH;
    localparam int SCR_W        = tcpw_pkg::SCREEN_WIDTH_DEF;
    localparam int SCR_H        = tcpw_pkg::SCREEN_HEIGHT_DEF;
    localparam int STRIDE       = tcpw_pkg::LINE_STRIDE_DEF;
    localparam int GLYPHS       = tcpw_pkg::FONT_GLYPHS_DEF;
    localparam int FONT_CELLS   = GLYPHS * GBYTES;
    localparam int ROW_LIMIT    = 2047;
    localparam int IDLE_PCT     = 38;
    localparam int SETTLE_TICKS = 150;
    localparam int PHASES       = 6;
    localparam logic [KW-1:0] KIND_UNUSED = 2'd3;

    typedef struct {
        logic [KW-1:0]        kind;
        logic [FW-1:0]        faddr;
        logic [BW-1:0]        fbyte;
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        logic [BW-1:0]        code;
        bit                   drain;
    } t_cmd;

    typedef struct {
        logic [AW-1:0] addr;
        logic [BW-1:0] color;
        logic          last;
    } t_pixel_word;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [tcpw_pkg::APB_AW-1:0] paddr;
    logic [tcpw_pkg::APB_DW-1:0] pwdata;
    logic [tcpw_pkg::APB_DW-1:0] prdata;
    logic pready;

    tcpw_in_if  in_if ();
    tcpw_out_if out_if ();

    text_char_pixel_writer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state
    logic [BW-1:0]        font_model [FONT_CELLS];
    logic [BW-1:0]        text_model;
    logic [BW-1:0]        bg_model;
    logic signed [CW-1:0] cur_col;
    logic signed [CW-1:0] cur_row;

    t_cmd        cmd_backlog [$];
    t_cmd        cmd_on_bus;
    t_pixel_word pixel_words_due [$];
    t_pixel_word got_word;
    t_pixel_word want_word;

    // stimulus bookkeeping: only glyphs with all five columns loaded get drawn
    bit gen_written [FONT_CELLS];
    bit glyph_listed [GLYPHS];
    int ready_glyphs [$];

    bit no_idle = 1'b0;
    int errors = 0;
    int n_loads = 0, n_cursor = 0, n_chars = 0, n_unused = 0, n_words = 0;

    task automatic report(string msg);
        errors++;
        if (errors <= 10)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic void render_char(logic [BW-1:0] code);
        t_pixel_word words [$];
        t_pixel_word w;
        logic [BW-1:0] bits;
        logic [31:0] lin;
        int px, py, ncol, nrow;
        bit ink;
        if (cur_col >= 0 && cur_col < SCR_W && cur_row >= 0 && cur_row < SCR_H) begin
            for (int col = 0; col < GCOLS; col++) begin
                if (col < GBYTES && int'(code) < GLYPHS)
                    bits = font_model[int'(code) * GBYTES + col];
                else
                    bits = '0;
                for (int row = 0; row < GROWS; row++) begin
                    ink = bits[row];
                    if (ink || bg_model != text_model) begin
                        px = cur_col + col;
                        py = cur_row + row;
                        if (px < SCR_W && py < SCR_H) begin
                            lin     = STRIDE * py + px;
                            w.addr  = lin[AW-1:0];
                            w.color = ink ? text_model : bg_model;
                            w.last  = 1'b0;
                            words.push_back(w);
                        end
                    end
                end
            end
            if (words.size() > 0)
                words[words.size()-1].last = 1'b1;
            foreach (words[k])
                pixel_words_due.push_back(words[k]);
        end
        // advance the cursor, wrapping at the right edge
        ncol = cur_col + GCOLS;
        nrow = cur_row;
        if (ncol > SCR_W - GCOLS) begin
            ncol = 0;
            nrow = cur_row + GROWS;
            if (nrow > ROW_LIMIT)
                nrow = ROW_LIMIT;
        end
        cur_col = CW'(ncol);
        cur_row = CW'(nrow);
    endfunction

    function automatic void apply_cmd(t_cmd c);
        case (c.kind)
            tcpw_pkg::KIND_LOAD: begin
                n_loads++;
                if (int'(c.faddr) < FONT_CELLS)
                    font_model[c.faddr] = c.fbyte;
            end
            tcpw_pkg::KIND_CURSOR: begin
                n_cursor++;
                cur_col = c.sx;
                cur_row = c.sy;
            end
            tcpw_pkg::KIND_CHAR: begin
                n_chars++;
                render_char(c.code);
            end
            default: n_unused++;
        endcase
    endfunction

    // command driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready)
                apply_cmd(cmd_on_bus);
            if (!in_if.valid || in_if.ready) begin
                if (cmd_backlog.size() > 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)
                    && !(cmd_backlog[0].drain && pixel_words_due.size() > 0)) begin
                    cmd_on_bus = cmd_backlog.pop_front();
                    in_if.kind         <= cmd_on_bus.kind;
                    in_if.font_address <= cmd_on_bus.faddr;
                    in_if.font_byte    <= cmd_on_bus.fbyte;
                    in_if.start_x      <= cmd_on_bus.sx;
                    in_if.start_y      <= cmd_on_bus.sy;
                    in_if.char_code    <= cmd_on_bus.code;
                    in_if.valid        <= 1'b1;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // pixel word monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            if (out_if.valid && out_if.ready) begin
                got_word.addr  = out_if.pixel_address;
                got_word.color = out_if.pixel_color;
                got_word.last  = out_if.last;
                if (pixel_words_due.size() == 0) begin
                    report($sformatf("unexpected word addr=%0d color=%0d last=%0b",
                                     got_word.addr, got_word.color, got_word.last));
                end else begin
                    want_word = pixel_words_due.pop_front();
                    n_words++;
                    if (got_word.addr !== want_word.addr || got_word.color !== want_word.color
                        || got_word.last !== want_word.last)
                        report($sformatf("exp addr=%0d color=%0d last=%0b, got addr=%0d color=%0d last=%0b",
                                         want_word.addr, want_word.color, want_word.last,
                                         got_word.addr, got_word.color, got_word.last));
                end
            end
        end
    end

    function automatic t_cmd random_cmd();
        t_cmd c;
        c.kind  = KW'($urandom_range(3));
        c.faddr = FW'($urandom_range(2047));
        c.fbyte = BW'($urandom_range(255));
        c.sx    = CW'($urandom_range(4095));
        c.sy    = CW'($urandom_range(4095));
        c.code  = BW'($urandom_range(255));
        c.drain = 1'b0;
        return c;
    endfunction

    function automatic int random_byte();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return 0;
        if (pick == 1)
            return 255;
        return $urandom_range(255);
    endfunction

    task automatic add_load(int addr, int val);
        t_cmd c;
        int g;
        bit full;
        c = random_cmd();
        c.kind  = tcpw_pkg::KIND_LOAD;
        c.faddr = FW'(addr);
        c.fbyte = BW'(val);
        cmd_backlog.push_back(c);
        if (addr < FONT_CELLS) begin
            gen_written[addr] = 1'b1;
            g = addr / GBYTES;
            full = 1'b1;
            for (int k = 0; k < GBYTES; k++)
                full &= gen_written[g * GBYTES + k];
            if (full && !glyph_listed[g]) begin
                glyph_listed[g] = 1'b1;
                ready_glyphs.push_back(g);
            end
        end
    endtask

    task automatic add_glyph(int g);
        for (int k = 0; k < GBYTES; k++)
            add_load(g * GBYTES + k, random_byte());
    endtask

    task automatic add_cursor(int x, int y);
        t_cmd c;
        c = random_cmd();
        c.kind = tcpw_pkg::KIND_CURSOR;
        c.sx   = CW'(x);
        c.sy   = CW'(y);
        cmd_backlog.push_back(c);
    endtask

    task automatic add_char(int code, bit drain);
        t_cmd c;
        c = random_cmd();
        c.kind  = tcpw_pkg::KIND_CHAR;
        c.code  = BW'(code);
        c.drain = drain;
        cmd_backlog.push_back(c);
    endtask

    task automatic add_unused();
        t_cmd c;
        c = random_cmd();
        c.kind = KIND_UNUSED;
        cmd_backlog.push_back(c);
    endtask

    // wait for the block to go quiet, then give a possible blank character time to finish
    task automatic settle();
        while (cmd_backlog.size() != 0 || in_if.valid || pixel_words_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_reg(tcpw_pkg::t_reg idx, logic [BW-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(tcpw_pkg::APB_DW-BW){1'b0}}, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == tcpw_pkg::REG_TEXT_COLOR)
            text_model = val;
        else
            bg_model = val;
    endtask

    task automatic set_colors(int txt, int bg);
        write_reg(tcpw_pkg::REG_TEXT_COLOR, BW'(txt));
        write_reg(tcpw_pkg::REG_BG_COLOR, BW'(bg));
    endtask

    task automatic run_directed();
        // glyph 0 and the top glyph, which ends at the last font address
        add_load(0, 8'h00); add_load(1, 8'hFF); add_load(2, 8'h01);
        add_load(3, 8'h80); add_load(4, 8'h55);
        add_load(1275, 8'hAA); add_load(1276, 8'hFF); add_load(1277, 8'h7F);
        add_load(1278, 8'hFE); add_load(1279, 8'h00);
        // loads past the font are dropped
        add_load(2047, 8'hFF);
        add_load(FONT_CELLS, 8'h12);
        add_unused();
        add_cursor(0, 0);
        add_char(0, 1'b0);
        add_char(255, 1'b0);
        // clip at right and bottom edges, then wrap
        add_cursor(716, 346);
        add_char(255, 1'b0);
        add_cursor(713, 343);
        add_char(0, 1'b0);
        // off screen in every direction; the one at 2047, 2047 saturates the row
        add_cursor(-2048, -2048);
        add_char(0, 1'b0);
        add_cursor(720, 0);
        add_char(255, 1'b0);
        add_cursor(0, 351);
        add_char(0, 1'b0);
        add_cursor(2047, 2047);
        add_char(255, 1'b0);
        add_char(0, 1'b1);
    endtask

    task automatic run_random(int n);
        int made, pick, g;
        made = 0;
        while (made < n) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                g = $urandom_range(GLYPHS - 1);
                add_glyph(g);
                add_char(g, 1'b0);
                made += GBYTES + 1;
            end else if (pick < 22) begin
                g = $urandom_range(99);
                if (g < 70)
                    add_cursor($urandom_range(SCR_W - 1), $urandom_range(SCR_H - 1));
                else if (g < 85)
                    add_cursor($urandom_range(SCR_W - 1, SCR_W - 20),
                               $urandom_range(SCR_H - 1, SCR_H - 20));
                else
                    add_cursor($urandom_range(4095), $urandom_range(4095));
                made++;
            end else if (pick < 30) begin
                // noise: unused kind, dropped loads, stray font writes
                g = $urandom_range(2);
                if (g == 0)
                    add_unused();
                else if (g == 1)
                    add_load($urandom_range(2047, FONT_CELLS), $urandom_range(255));
                else
                    add_load($urandom_range(FONT_CELLS - 1), random_byte());
            end else begin
                add_char(ready_glyphs[$urandom_range(ready_glyphs.size() - 1)],
                         $urandom_range(99) < 3);
                made++;
            end
        end
    endtask

    initial begin
        int txt [PHASES];
        int bg [PHASES];
        txt = '{0, 255, 0, 0, 0, 0};
        bg  = '{255, 255, 0, 0, 0, 0};
        txt[3] = $urandom_range(255);
        bg[3]  = txt[3] ^ $urandom_range(255, 1);
        txt[4] = $urandom_range(255);
        bg[4]  = $urandom_range(255);
        txt[5] = $urandom_range(255);
        bg[5]  = txt[5];

        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        in_if.valid        = 1'b0;
        in_if.kind         = tcpw_pkg::KIND_LOAD;
        in_if.font_address = '0;
        in_if.font_byte    = '0;
        in_if.start_x      = '0;
        in_if.start_y      = '0;
        in_if.char_code    = '0;
        out_if.ready       = 1'b0;
        text_model = '0;
        bg_model   = '0;
        cur_col    = '0;
        cur_row    = '0;
        foreach (font_model[k])
            font_model[k] = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_colors(255, 0);
        run_directed();
        settle();

        for (int p = 0; p < PHASES; p++) begin
            set_colors(txt[p], bg[p]);
            no_idle = (p == 3);
            run_random(70);
            settle();
        end
        no_idle = 1'b0;

        if (pixel_words_due.size() != 0)
            report($sformatf("%0d pixel words never arrived", pixel_words_due.size()));

        $display("Covered %0d font loads, %0d cursor moves, %0d characters, %0d unused commands",
                 n_loads, n_cursor, n_chars, n_unused);
        $display("Checked %0d pixel words over %0d color settings, %0d errors",
                 n_words, PHASES + 1, errors);
        if (errors == 0) begin
            $display("PASS text_char_pixel_writer");
        end else begin
            $display("FAIL text_char_pixel_writer");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("FAIL text_char_pixel_writer");
        $finish;
    end

endmodule
